>>> sv/ole_pkg.sv
package ole_pkg;

  localparam int DataW       = 32;
  localparam int ActW        = 3;
  localparam int StatW       = 2;
  localparam int DefCapacity = 16;

  typedef enum logic [ActW-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AFTER = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DUMP      = 3'd5
  } action_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_INS_AFTER = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_ROTATE    = 3'd5
  } cell_op_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e                op;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] key;
  } cell_cmd_t;

  // Where a cell sits relative to the current list length.
  typedef struct packed {
    logic head;      // first cell of the chain
    logic tail;      // holds the back entry
    logic past;      // first free slot
    logic occupied;  // holds a live entry
  } cell_pos_t;

endpackage

>>> sv/ole_cell.sv
module ole_cell (
  input  logic                             clk_i,
  input  ole_pkg::cell_cmd_t               cmd_i,
  input  ole_pkg::cell_pos_t               pos_i,
  input  logic signed [ole_pkg::DataW-1:0] left_i,
  input  logic signed [ole_pkg::DataW-1:0] right_i,
  input  logic signed [ole_pkg::DataW-1:0] wrap_i,
  input  logic                             hit_i,
  input  logic                             load_i,
  output logic signed [ole_pkg::DataW-1:0] value_o,
  output logic                             hit_o,
  output logic                             load_o
);
  import ole_pkg::*;

  logic signed [DataW-1:0] value_q, value_d;
  logic                    match;

  assign match   = pos_i.occupied && (value_q == cmd_i.key);
  assign hit_o   = hit_i | match;
  // Only the first matching cell asks its right neighbor to take the new value.
  assign load_o  = match & ~hit_i;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      OP_INS_FRONT: value_d = pos_i.head ? cmd_i.value : left_i;
      OP_INS_BACK: begin
        if (pos_i.past) value_d = cmd_i.value;
      end
      OP_INS_AFTER: begin
        if (load_i) begin
          value_d = cmd_i.value;
        end else if (hit_i) begin
          value_d = left_i;
        end
      end
      OP_DEL_FRONT: value_d = right_i;
      // close the ring at the back entry so a full pass restores the order
      OP_ROTATE: value_d = pos_i.tail ? wrap_i : right_i;
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> sv/ordered_list_engine.sv
// Channel   Direction  Handshake              Beat payload
// input     in         in_valid_i/in_stall_o   action_i, item_value_i, search_key_i
// output    out        out_valid_o/out_stall_i status_o, entry_value_o, last_result_o
//
// In every edit, all cells compare against the key and shift at once.
// A dump of N entries holds the input while the chain rotates one place per cycle,
// as long as the output is free, and the head cell is sent out; an empty list answers STAT_EMPTY.
// Reset empties the list; cell contents are left as they are.
// A stalled output holds its beat and the input stalls until the slot frees.
module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::DefCapacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ole_pkg::ActW-1:0]         action_i,
  input  logic signed [ole_pkg::DataW-1:0] item_value_i,
  input  logic signed [ole_pkg::DataW-1:0] search_key_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ole_pkg::StatW-1:0]        status_o,
  output logic signed [ole_pkg::DataW-1:0] entry_value_o,
  output logic                             last_result_o
);
  import ole_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   remain_q, remain_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic signed [DataW-1:0] entry_q, entry_d;
  logic              last_q, last_d;

  cell_cmd_t               cmd;
  cell_pos_t               pos   [CAPACITY];
  logic signed [DataW-1:0] value [CAPACITY];
  logic                    hit   [CAPACITY+1];
  logic                    load  [CAPACITY+1];

  logic    out_free, accept_in, full, empty, found, emit;
  status_e emit_status;
  action_e action;

  assign action    = action_e'(action_i);
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) | ~out_free;
  assign accept_in = in_valid_i & ~in_stall_o;
  assign full      = (count_q == CntW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign found     = hit[CAPACITY];

  assign hit[0]  = 1'b0;
  assign load[0] = 1'b0;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    assign pos[j].head     = (j == 0);
    assign pos[j].tail     = (count_q == CntW'(j + 1));
    assign pos[j].past     = (count_q == CntW'(j));
    assign pos[j].occupied = (count_q > CntW'(j));

    ole_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos[j]),
      .left_i  ((j == 0) ? '0 : value[(j == 0) ? 0 : j - 1]),
      .right_i ((j == CAPACITY - 1) ? '0 : value[(j == CAPACITY - 1) ? j : j + 1]),
      .wrap_i  (value[0]),
      .hit_i   (hit[j]),
      .load_i  (load[j]),
      .value_o (value[j]),
      .hit_o   (hit[j+1]),
      .load_o  (load[j+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    remain_d    = remain_q;
    cmd.op      = OP_HOLD;
    cmd.value   = item_value_i;
    cmd.key     = search_key_i;
    emit        = 1'b0;
    emit_status = STAT_OK;
    entry_d     = '0;
    last_d      = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          case (action)
            ACT_INS_FRONT, ACT_INS_BACK: begin
              emit = 1'b1;
              if (full) begin
                emit_status = STAT_FULL;
              end else begin
                cmd.op  = (action == ACT_INS_FRONT) ? OP_INS_FRONT : OP_INS_BACK;
                count_d = count_q + 1'b1;
              end
            end
            ACT_INS_AFTER: begin
              emit = 1'b1;
              if (full) begin
                emit_status = STAT_FULL;
              end else if (!found) begin
                emit_status = STAT_NOT_FOUND;
              end else begin
                cmd.op  = OP_INS_AFTER;
                count_d = count_q + 1'b1;
              end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = STAT_EMPTY;
              end else begin
                if (action == ACT_DEL_FRONT) cmd.op = OP_DEL_FRONT;
                count_d = count_q - 1'b1;
              end
            end
            ACT_DUMP: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                state_d  = ST_DUMP;
                remain_d = count_q;
              end
            end
            default: ;  // drop undefined actions without a result
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          cmd.op   = OP_ROTATE;
          emit     = 1'b1;
          entry_d  = value[0];
          last_d   = (remain_q == CntW'(1));
          remain_d = remain_q - 1'b1;
          if (last_d) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    status_d    = emit_status;
    out_valid_d = emit ? 1'b1 : (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= status_d;
      entry_q  <= entry_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_value_o = entry_q;
  assign last_result_o = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("list length beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> (count_q == $past(count_q) + 1'b1) ||
                                  (count_q == $past(count_q) - 1'b1))
    else $error("list length moved by more than one");

  a_dump_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |=> count_q == $past(count_q))
    else $error("list length changed during dump");

  a_dump_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> in_stall_o)
    else $error("input taken during dump");

  a_dump_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> (remain_q != '0) && (remain_q <= count_q))
    else $error("dump counter out of range");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ole_pkg::*;

  localparam int Capacity  = DefCapacity;
  localparam int RandItems = 228;
  localparam logic [ActW-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ActW-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic signed [DataW-1:0] MaxWord = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] MinWord = 32'sh8000_0000;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] value;
    logic                    last;
  } answer_t;

  typedef struct packed {
    logic [ActW-1:0]         act;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] key;
    logic                    pinned;
    status_e                 want;
    logic                    fill;
  } step_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ActW-1:0]         action_i;
  logic signed [DataW-1:0] item_value_i;
  logic signed [DataW-1:0] search_key_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [StatW-1:0]        status_o;
  logic signed [DataW-1:0] entry_value_o;
  logic                    last_result_o;

  ordered_list_engine #(.CAPACITY(Capacity)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .item_value_i (item_value_i),
    .search_key_i (search_key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .entry_value_o(entry_value_o),
    .last_result_o(last_result_o)
  );

  // Shadow copy of the list and the answers it still owes.
  logic signed [DataW-1:0] shadow_entries [Capacity];
  int                      shadow_count = 0;
  answer_t                 answer_q [$];
  step_t                   plan_q [$];

  logic    pin_on = 1'b0;
  answer_t pin_answer;

  int mismatches   = 0;
  int beats_in     = 0;
  int results_seen = 0;
  int dumps_full   = 0;
  int full_drops   = 0;
  int key_misses   = 0;
  int longest      = 0;
  int holds        = 0;

  int burst_left  = 0;
  int gap_max     = 0;
  int stall_style = 0;
  int tick        = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("FAILURE");
    $finish;
  end

  // Receiver back-pressure: none, random, or a fixed 3-of-7 pattern.
  always @(negedge clk_i) begin
    tick <= tick + 1;
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(99) < 35);
      default: out_stall_i <= ((tick % 7) < 3);
    endcase
  end

  task automatic note_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_answer(input status_e st, input logic signed [DataW-1:0] val,
                              input logic last);
    answer_t a;
    a.status = st;
    a.value  = val;
    a.last   = last;
    answer_q.push_back(a);
  endtask

  task automatic open_slot(input int pos, input logic signed [DataW-1:0] val);
    for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[pos] = val;
    shadow_count++;
    if (shadow_count > longest) longest = shadow_count;
  endtask

  // Apply one action to the shadow list and queue the beats it should produce.
  task automatic apply_list_action(input logic [ActW-1:0] act,
                                   input logic signed [DataW-1:0] val,
                                   input logic signed [DataW-1:0] key);
    int hit;
    hit = -1;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AFTER: begin
        if (shadow_count >= Capacity) begin
          full_drops++;
          queue_answer(STAT_FULL, '0, 1'b1);
        end else if (act == ACT_INS_FRONT) begin
          open_slot(0, val);
          queue_answer(STAT_OK, '0, 1'b1);
        end else if (act == ACT_INS_BACK) begin
          open_slot(shadow_count, val);
          queue_answer(STAT_OK, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_entries[i] == key) hit = i;
          if (hit < 0) begin
            key_misses++;
            queue_answer(STAT_NOT_FOUND, '0, 1'b1);
          end else begin
            open_slot(hit + 1, val);
            queue_answer(STAT_OK, '0, 1'b1);
          end
        end
      end
      ACT_DEL_FRONT, ACT_DEL_BACK: begin
        if (shadow_count == 0) begin
          queue_answer(STAT_EMPTY, '0, 1'b1);
        end else begin
          if (act == ACT_DEL_FRONT)
            for (int i = 0; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
          queue_answer(STAT_OK, '0, 1'b1);
        end
      end
      ACT_DUMP: begin
        if (shadow_count == 0) begin
          queue_answer(STAT_EMPTY, '0, 1'b1);
        end else begin
          dumps_full++;
          for (int i = 0; i < shadow_count; i++)
            queue_answer(STAT_OK, shadow_entries[i], (i + 1 == shadow_count));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : watch
    answer_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        beats_in++;
        apply_list_action(action_i, item_value_i, search_key_i);
        // A pinned step replaces the predicted beat with the typed-in one.
        if (pin_on && answer_q.size() != 0) begin
          answer_q.delete(answer_q.size() - 1);
          answer_q.push_back(pin_answer);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          note_mismatch($sformatf("unexpected beat status=%0d value=%0d last=%0b",
                                  status_o, entry_value_o, last_result_o));
        end else begin
          want = answer_q.pop_front();
          if (status_o !== want.status || entry_value_o !== want.value ||
              last_result_o !== want.last)
            note_mismatch($sformatf("got status=%0d value=%0d last=%0b, want %0d %0d %0b",
                                    status_o, entry_value_o, last_result_o,
                                    want.status, want.value, want.last));
        end
      end
    end
  end

  // Drive one beat, with a random gap between bursts; return once it is taken.
  task automatic send_beat(input logic [ActW-1:0] act, input logic signed [DataW-1:0] val,
                           input logic signed [DataW-1:0] key, input logic pin,
                           input status_e want);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      in_valid_i = 1'b0;
      repeat (gap) begin
        action_i     = $urandom_range(7);
        item_value_i = $urandom;
        search_key_i = $urandom;
        @(negedge clk_i);
      end
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
    in_valid_i        = 1'b1;
    action_i          = act;
    item_value_i      = val;
    search_key_i      = key;
    pin_on            = pin;
    pin_answer.status = want;
    pin_answer.value  = '0;
    pin_answer.last   = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [DataW-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(7) - 4;
    if (r < 40) begin
      case ($urandom_range(3))
        0: return MaxWord;
        1: return MinWord;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic plan_step(input logic [ActW-1:0] act, input logic signed [DataW-1:0] val,
                           input logic signed [DataW-1:0] key, input logic pin,
                           input status_e want, input logic fill);
    step_t s;
    s.act    = act;
    s.value  = val;
    s.key    = key;
    s.pinned = pin;
    s.want   = want;
    s.fill   = fill;
    plan_q.push_back(s);
  endtask

  initial begin : stimulus
    int random_items;
    int phase_left;
    int r;
    logic [ActW-1:0] act;
    logic signed [DataW-1:0] key;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = '0;
    item_value_i = '0;
    search_key_i = '0;
    random_items = 0;
    phase_left   = 0;

    //        action          value    key      pin   typed result    fill
    plan_step(ACT_DEL_FRONT,  0,       0,       1'b1, STAT_EMPTY,     1'b0);
    plan_step(ACT_DEL_BACK,   -1,      -1,      1'b1, STAT_EMPTY,     1'b0);
    plan_step(ACT_DUMP,       0,       0,       1'b1, STAT_EMPTY,     1'b0);
    plan_step(ACT_INS_AFTER,  5,       0,       1'b1, STAT_NOT_FOUND, 1'b0);
    plan_step(ACT_INS_FRONT,  MaxWord, 0,       1'b1, STAT_OK,        1'b0);
    plan_step(ACT_INS_BACK,   MinWord, 0,       1'b1, STAT_OK,        1'b0);
    plan_step(ACT_INS_AFTER,  -1,      MaxWord, 1'b1, STAT_OK,        1'b0);
    plan_step(ACT_INS_AFTER,  9,       MinWord, 1'b1, STAT_OK,        1'b0);
    plan_step(ACT_INS_AFTER,  3,       12345,   1'b1, STAT_NOT_FOUND, 1'b0);
    plan_step(ACT_DUMP,       0,       0,       1'b0, STAT_OK,        1'b0);
    plan_step(ACT_SPARE_LO,   MinWord, MaxWord, 1'b0, STAT_OK,        1'b0);
    plan_step(ACT_SPARE_HI,   MaxWord, MinWord, 1'b0, STAT_OK,        1'b0);
    plan_step(ACT_INS_FRONT,  -1,      0,       1'b0, STAT_OK,        1'b0);
    plan_step(ACT_INS_AFTER,  0,       -1,      1'b0, STAT_OK,        1'b0);
    plan_step(ACT_DEL_BACK,   0,       0,       1'b1, STAT_OK,        1'b0);
    plan_step(ACT_DEL_FRONT,  0,       0,       1'b1, STAT_OK,        1'b0);
    plan_step(ACT_DUMP,       0,       0,       1'b0, STAT_OK,        1'b0);
    plan_step(ACT_INS_BACK,   0,       0,       1'b0, STAT_OK,        1'b1);
    plan_step(ACT_INS_FRONT,  1,       0,       1'b1, STAT_FULL,      1'b0);
    plan_step(ACT_INS_BACK,   2,       0,       1'b1, STAT_FULL,      1'b0);
    plan_step(ACT_INS_AFTER,  3,       MaxWord, 1'b1, STAT_FULL,      1'b0);
    plan_step(ACT_INS_AFTER,  4,       777,     1'b1, STAT_FULL,      1'b0);
    plan_step(ACT_DUMP,       0,       0,       1'b0, STAT_OK,        1'b0);
    plan_step(ACT_DEL_FRONT,  0,       0,       1'b0, STAT_OK,        1'b0);
    plan_step(ACT_DEL_BACK,   0,       0,       1'b0, STAT_OK,        1'b0);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    stall_style = 1;
    gap_max     = 3;
    foreach (plan_q[k]) begin
      if (plan_q[k].fill) begin
        // Top the list up to capacity with assorted values.
        while (shadow_count < Capacity)
          send_beat(plan_q[k].act, pick_word(), $urandom, 1'b0, STAT_OK);
      end else begin
        send_beat(plan_q[k].act, plan_q[k].value, plan_q[k].key, plan_q[k].pinned,
                  plan_q[k].want);
      end
    end

    begin : random_part
      int grow_bias;
      grow_bias = 50;
      while (random_items < RandItems) begin
        if (phase_left == 0) begin
          // Drain everything before some phase changes.
          if (holds == 0 || $urandom_range(2) == 0) begin
            in_valid_i = 1'b0;
            while (answer_q.size() != 0) @(negedge clk_i);
            holds++;
          end
          case ($urandom_range(2))
            0: grow_bias = 80;
            1: grow_bias = 50;
            default: grow_bias = 20;
          endcase
          stall_style = $urandom_range(2);
          gap_max     = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
          phase_left  = $urandom_range(40, 20);
        end
        phase_left--;
        r   = $urandom_range(99);
        key = $urandom;
        if (r < 3) begin
          act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        end else if (r < 15) begin
          act = ACT_DUMP;
        end else if ($urandom_range(99) < grow_bias) begin
          case ($urandom_range(4))
            0, 1: act = ACT_INS_AFTER;
            2: act = ACT_INS_FRONT;
            default: act = ACT_INS_BACK;
          endcase
          if (act == ACT_INS_AFTER) begin
            if (shadow_count != 0 && $urandom_range(3) != 0)
              key = shadow_entries[$urandom_range(shadow_count - 1)];
            else if ($urandom_range(1) == 0)
              key = pick_word();
          end
        end else begin
          act = $urandom_range(1) ? ACT_DEL_BACK : ACT_DEL_FRONT;
        end
        send_beat(act, pick_word(), key, 1'b0, STAT_OK);
        if (act != ACT_SPARE_LO && act != ACT_SPARE_HI) random_items++;
      end
    end

    in_valid_i = 1'b0;
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (Capacity + 8) @(negedge clk_i);

    $display("Drove %0d beats: %0d non-empty dumps, %0d full drops, %0d missing keys.",
             beats_in, dumps_full, full_drops, key_misses);
    $display("Checked %0d result beats; longest list %0d, %0d full drains.",
             results_seen, longest, holds);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> ordered_list_engine.f
sv/ole_pkg.sv
sv/ole_cell.sv
sv/ordered_list_engine.sv
bench/testbench.sv
